>>> sv/array_backed_linked_list_core_macros.svh
// ----------------------------------------------------------------------------
// array_backed_linked_list_core_macros
// assertion shorthands shared by the linked list core
// ----------------------------------------------------------------------------
`ifndef ARRAY_BACKED_LINKED_LIST_CORE_MACROS_SVH
`define ARRAY_BACKED_LINKED_LIST_CORE_MACROS_SVH

// cond must never hold outside reset
`define ABLL_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// when trig holds, res holds in the next cycle
`define ABLL_NEXT(lbl, trig, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (res)) \
		else $error(msg);

`endif

>>> sv/abll_pkg.sv
// ----------------------------------------------------------------------------
// abll_pkg
// types, constants and command/status bundles of the linked list core
// ----------------------------------------------------------------------------
package abll_pkg;

	localparam int DEPTH  = 128;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LOCATE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		RS_OK      = 2'd0,
		RS_BAD     = 2'd1,
		RS_FULL    = 2'd2,
		RS_MISSING = 2'd3
	} res_code_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_POP,
		ST_IWALK,
		ST_ILINK,
		ST_WALK,
		ST_DUNLINK,
		ST_DFREE,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		RD_FREE,
		RD_HEAD,
		RD_LINK,
		RD_IDX
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NODE_LNK,
		WR_CURR_NODE,
		WR_CURR_LNK,
		WR_IDX_FREE
	} wr_sel_t;

	typedef enum logic [1:0] {
		RI_ZERO,
		RI_IDX,
		RI_NODE
	} idx_sel_t;

	typedef struct packed {
		logic      load;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_en;
		wr_sel_t   wr_sel;
		logic      data_wr;
		logic      take_free;
		logic      take_hw;
		logic      walk_start;
		logic      walk_adv;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      free_push;
		logic      res_load;
		res_code_t res_status;
		idx_sel_t  res_idx_sel;
		logic      res_pos_step;
	} abll_cmd_t;

	typedef struct packed {
		logic [1:0]       action;
		logic             pos_bad;
		logic             free_empty;
		logic             hw_full;
		logic             idx_bad;
		logic             lnk_null;
		logic             lnk_hit;
		logic             step_over;
		logic             step_at_pos;
		logic [CNT_W-1:0] cnt;
	} abll_sts_t;

endpackage

>>> sv/abll_dpath.sv
// ----------------------------------------------------------------------------
// abll_dpath
// node stores, list pointers, walk counter and result register
// ----------------------------------------------------------------------------
module abll_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  abll_pkg::abll_cmd_t               cmd,
	output abll_pkg::abll_sts_t               sts,
	input  logic [1:0]                        in_action,
	input  logic [abll_pkg::IDX_W-1:0]        in_pos,
	input  logic [abll_pkg::IDX_W-1:0]        in_idx,
	input  logic [abll_pkg::DATA_W-1:0]       in_val,
	output logic [1:0]                        res_status,
	output logic [abll_pkg::IDX_W-1:0]        res_index,
	output logic [abll_pkg::IDX_W-1:0]        res_position,
	output logic                              res_empty,
	output logic                              res_full
);

	localparam int IW = abll_pkg::IDX_W;
	localparam int CW = abll_pkg::CNT_W;

	logic [abll_pkg::DATA_W-1:0] data_mem [abll_pkg::DEPTH];
	logic [IW-1:0]               link_mem [abll_pkg::DEPTH];

	logic [1:0]                  act_q;
	logic [IW-1:0]               pos_q;
	logic [IW-1:0]               idx_q;
	logic [abll_pkg::DATA_W-1:0] val_q;

	logic [IW-1:0] head_q;
	logic [IW-1:0] free_q;
	logic [IW-1:0] hw_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] node_q;
	logic [IW-1:0] curr_q;
	logic [CW-1:0] step_q;
	logic [IW-1:0] rdata_q;
	logic          rd_head_q;

	logic [1:0]    rstat_q;
	logic [IW-1:0] ridx_q;
	logic [IW-1:0] rpos_q;

	logic [IW-1:0] lnk;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] wr_data;
	logic [IW-1:0] hw_next;

	// head link lives in a flop so that reset leaves the list empty
	assign lnk     = rd_head_q ? head_q : rdata_q;
	assign hw_next = hw_q + IW'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			abll_pkg::RD_FREE: rd_addr = free_q;
			abll_pkg::RD_HEAD: rd_addr = '0;
			abll_pkg::RD_LINK: rd_addr = lnk;
			abll_pkg::RD_IDX:  rd_addr = idx_q;
			default:           rd_addr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			abll_pkg::WR_NODE_LNK: begin
				wr_addr = node_q;
				wr_data = lnk;
			end
			abll_pkg::WR_CURR_NODE: begin
				wr_addr = curr_q;
				wr_data = node_q;
			end
			abll_pkg::WR_CURR_LNK: begin
				wr_addr = curr_q;
				wr_data = lnk;
			end
			abll_pkg::WR_IDX_FREE: begin
				wr_addr = idx_q;
				wr_data = free_q;
			end
			default: begin
				wr_addr = '0;
				wr_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= link_mem[rd_addr];
		end
		if (cmd.wr_en && wr_addr != '0) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (cmd.data_wr) begin
			data_mem[node_q] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			free_q    <= '0;
			hw_q      <= '0;
			cnt_q     <= '0;
			rd_head_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_head_q <= (rd_addr == '0);
			end
			if (cmd.wr_en && wr_addr == '0) begin
				head_q <= wr_data;
			end
			if (cmd.take_free) begin
				free_q <= lnk;
			end else if (cmd.free_push) begin
				free_q <= idx_q;
			end
			if (cmd.take_hw) begin
				hw_q <= hw_next;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			pos_q <= in_pos;
			idx_q <= in_idx;
			val_q <= in_val;
		end
		if (cmd.take_free) begin
			node_q <= free_q;
		end else if (cmd.take_hw) begin
			node_q <= hw_next;
		end
		if (cmd.walk_start) begin
			curr_q <= '0;
			step_q <= CW'(1);
		end else if (cmd.walk_adv) begin
			curr_q <= lnk;
			step_q <= step_q + CW'(1);
		end
		if (cmd.res_load) begin
			rstat_q <= cmd.res_status;
			rpos_q  <= cmd.res_pos_step ? step_q[IW-1:0] : '0;
			case (cmd.res_idx_sel)
				abll_pkg::RI_IDX:  ridx_q <= idx_q;
				abll_pkg::RI_NODE: ridx_q <= node_q;
				default:           ridx_q <= '0;
			endcase
		end
	end

	always_comb begin
		sts.action      = act_q;
		sts.pos_bad     = (pos_q == '0) || ({1'b0, pos_q} > cnt_q + CW'(1));
		sts.free_empty  = (free_q == '0);
		sts.hw_full     = (hw_q == IW'(abll_pkg::DEPTH - 1));
		sts.idx_bad     = (idx_q == '0) || (idx_q > hw_q);
		sts.lnk_null    = (lnk == '0);
		sts.lnk_hit     = (lnk == idx_q);
		sts.step_over   = (step_q > cnt_q);
		sts.step_at_pos = (step_q == {1'b0, pos_q});
		sts.cnt         = cnt_q;
	end

	assign res_status   = rstat_q;
	assign res_index    = ridx_q;
	assign res_position = rpos_q;
	assign res_empty    = (cnt_q == '0);
	assign res_full     = (cnt_q == CW'(abll_pkg::DEPTH - 1));

endmodule

>>> sv/abll_ctrl.sv
// ----------------------------------------------------------------------------
// abll_ctrl
// sequencer for allocation, link walks and relinking
// ----------------------------------------------------------------------------
module abll_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  abll_pkg::abll_sts_t  sts,
	output abll_pkg::abll_cmd_t  cmd
);

	abll_pkg::state_t state_q;
	abll_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abll_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		cmd              = '0;
		cmd.rd_sel       = abll_pkg::RD_HEAD;
		cmd.wr_sel       = abll_pkg::WR_NODE_LNK;
		cmd.res_status   = abll_pkg::RS_OK;
		cmd.res_idx_sel  = abll_pkg::RI_ZERO;
		in_ready         = 1'b0;
		out_valid        = 1'b0;

		unique case (state_q)
			abll_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = abll_pkg::ST_CHECK;
				end
			end

			abll_pkg::ST_CHECK: begin
				unique case (sts.action) inside
					abll_pkg::ACT_INSERT: begin
						if (sts.pos_bad) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = abll_pkg::RS_BAD;
							state_d        = abll_pkg::ST_RESP;
						end else if (!sts.free_empty) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = abll_pkg::RD_FREE;
							state_d    = abll_pkg::ST_POP;
						end else if (!sts.hw_full) begin
							cmd.take_hw    = 1'b1;
							cmd.walk_start = 1'b1;
							cmd.rd_en      = 1'b1;
							cmd.rd_sel     = abll_pkg::RD_HEAD;
							state_d        = abll_pkg::ST_IWALK;
						end else begin
							cmd.res_load   = 1'b1;
							cmd.res_status = abll_pkg::RS_FULL;
							state_d        = abll_pkg::ST_RESP;
						end
					end
					abll_pkg::ACT_DELETE, abll_pkg::ACT_LOCATE: begin
						if (sts.idx_bad) begin
							cmd.res_load    = 1'b1;
							cmd.res_status  = abll_pkg::RS_BAD;
							cmd.res_idx_sel = abll_pkg::RI_IDX;
							state_d         = abll_pkg::ST_RESP;
						end else begin
							cmd.walk_start = 1'b1;
							cmd.rd_en      = 1'b1;
							cmd.rd_sel     = abll_pkg::RD_HEAD;
							state_d        = abll_pkg::ST_WALK;
						end
					end
					default: begin
						cmd.res_load   = 1'b1;
						cmd.res_status = abll_pkg::RS_BAD;
						state_d        = abll_pkg::ST_RESP;
					end
				endcase
			end

			// link of the popped free node is on the read port now
			abll_pkg::ST_POP: begin
				cmd.take_free  = 1'b1;
				cmd.walk_start = 1'b1;
				cmd.rd_en      = 1'b1;
				cmd.rd_sel     = abll_pkg::RD_HEAD;
				state_d        = abll_pkg::ST_IWALK;
			end

			abll_pkg::ST_IWALK: begin
				if (sts.step_at_pos) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = abll_pkg::WR_NODE_LNK;
					cmd.data_wr = 1'b1;
					state_d     = abll_pkg::ST_ILINK;
				end else begin
					cmd.walk_adv = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = abll_pkg::RD_LINK;
				end
			end

			abll_pkg::ST_ILINK: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_sel      = abll_pkg::WR_CURR_NODE;
				cmd.cnt_inc     = 1'b1;
				cmd.res_load    = 1'b1;
				cmd.res_status  = abll_pkg::RS_OK;
				cmd.res_idx_sel = abll_pkg::RI_NODE;
				state_d         = abll_pkg::ST_RESP;
			end

			abll_pkg::ST_WALK: begin
				if (sts.step_over || sts.lnk_null) begin
					cmd.res_load    = 1'b1;
					cmd.res_status  = abll_pkg::RS_MISSING;
					cmd.res_idx_sel = abll_pkg::RI_IDX;
					state_d         = abll_pkg::ST_RESP;
				end else if (sts.lnk_hit) begin
					if (sts.action == abll_pkg::ACT_LOCATE) begin
						cmd.res_load     = 1'b1;
						cmd.res_status   = abll_pkg::RS_OK;
						cmd.res_idx_sel  = abll_pkg::RI_IDX;
						cmd.res_pos_step = 1'b1;
						state_d          = abll_pkg::ST_RESP;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = abll_pkg::RD_IDX;
						state_d    = abll_pkg::ST_DUNLINK;
					end
				end else begin
					cmd.walk_adv = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = abll_pkg::RD_LINK;
				end
			end

			// predecessor skips over the deleted node
			abll_pkg::ST_DUNLINK: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = abll_pkg::WR_CURR_LNK;
				state_d    = abll_pkg::ST_DFREE;
			end

			abll_pkg::ST_DFREE: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_sel      = abll_pkg::WR_IDX_FREE;
				cmd.free_push   = 1'b1;
				cmd.cnt_dec     = 1'b1;
				cmd.res_load    = 1'b1;
				cmd.res_status  = abll_pkg::RS_OK;
				cmd.res_idx_sel = abll_pkg::RI_IDX;
				state_d         = abll_pkg::ST_RESP;
			end

			abll_pkg::ST_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = abll_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = abll_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/array_backed_linked_list_core.sv
// ----------------------------------------------------------------------------
// array_backed_linked_list_core
// singly linked list in a fixed node store with a free list
//
//  channel | dir | beat contents
//  s_      | in  | tuser: action; tdata: list_position, node_index, value
//  m_      | out | tdata: status, result_index, result_position, is_empty, is_full
//
// one action at a time; an insert passes CHECK, POP (only when a node is
// popped from the free list), IWALK and ILINK; delete and locate pass CHECK
// and WALK, and a delete then passes DUNLINK and DFREE. the one-node-per-cycle
// walk runs over the link store read port; failed checks answer from CHECK.
// reset empties the list at once, no clearing pass. a stalled result
// holds the block; s_tready is low until the result beat is taken.
// ----------------------------------------------------------------------------
`include "array_backed_linked_list_core_macros.svh"

module array_backed_linked_list_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // list_position[6:0], node_index[13:7], value[45:14], zero pad
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // status[1:0], result_index[8:2], result_position[15:9],
	                              // is_empty[16], is_full[17], zero pad
);

	abll_pkg::abll_cmd_t cmd;
	abll_pkg::abll_sts_t sts;

	logic [1:0]                 res_status;
	logic [abll_pkg::IDX_W-1:0] res_index;
	logic [abll_pkg::IDX_W-1:0] res_position;
	logic                       res_empty;
	logic                       res_full;

	abll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	abll_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_action    (s_tuser),
		.in_pos       (s_tdata[6:0]),
		.in_idx       (s_tdata[13:7]),
		.in_val       (s_tdata[45:14]),
		.res_status   (res_status),
		.res_index    (res_index),
		.res_position (res_position),
		.res_empty    (res_empty),
		.res_full     (res_full)
	);

	assign m_tdata = {6'b0, res_full, res_empty, res_position, res_index, res_status};

	`ABLL_NEVER(a_one_at_a_time, s_tready && m_tvalid, "input taken while a result is pending")
	`ABLL_NEVER(a_count_range, sts.cnt > abll_pkg::CNT_W'(abll_pkg::DEPTH - 1), "node count overflow")
	`ABLL_NEXT(a_ready_after_beat, m_tvalid && m_tready, s_tready, "not idle after result beat")
	`ABLL_NEVER(a_full_empty, m_tvalid && res_full && res_empty, "list both full and empty")

endmodule
